// ===== hdl/sorted_multi_channel_soft_timer_core_assert.svh =====
// assertion macros shared by the checker
`ifndef SORTED_MULTI_CHANNEL_SOFT_TIMER_CORE_ASSERT_SVH
`define SORTED_MULTI_CHANNEL_SOFT_TIMER_CORE_ASSERT_SVH

`define SMT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smst_pkg;
    localparam int TIMER_COUNT_DEF = 16;
    localparam int TICK_WIDTH_DEF  = 32;
    localparam int ID_W            = 4;
    localparam int PERIOD_W        = 32;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_DELETE = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4,
        OP_CHPER  = 3'd5
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARAM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_REMOVE,
        S_INS_SEEK,
        S_INS_SHIFT,
        S_TICK_CHECK,
        S_TICK_EMIT,
        S_STAT_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic find_start; // reset scan position
        logic pos_inc;
        logic tpos_inc;   // step tick scan over an entry that already fired
        logic remove;     // drop list entry at scan position
        logic ins_prep;   // compute expiry of target, reset scan
        logic ins_tick;   // target expiry = own + period
        logic ins_shift;  // put target at scan position, shift rest
        logic set_active;
        logic clr_active;
        logic create;
        logic delete;
        logic set_period;
        logic tick_inc;
        logic mark_fired;
        logic emit_evt;
        logic emit_stat;
        logic last;       // send held fired word as the final one of the tick
        logic [1:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic hvalid;
        logic per_zero;
        logic act;
        logic have_free;
        logic scan_end;   // scan position reached list length
        logic scan_hit;   // entry at scan position is target
        logic ins_here;   // entry at scan position is later than target
        logic tick_end;   // tick scan position reached list length
        logic head_fired; // entry at tick scan position already fired
        logic head_due;
        logic head_periodic;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

// ===== hdl/smst_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smst_datapath #(
    parameter int TIMER_COUNT = 16,
    parameter int TICK_WIDTH  = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [47:0]       i_word,
    input  wire smst_pkg::t_cmd    i_cmd,
    output smst_pkg::t_sts         o_sts,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_data,
    output logic                   o_last
);
    import smst_pkg::*;
    localparam int SW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CW = $clog2(TIMER_COUNT + 1);

    logic [2:0]            r_op;
    logic [ID_W-1:0]       r_handle;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_mode;
    logic [TICK_WIDTH-1:0] r_tick;
    logic [TIMER_COUNT-1:0] r_alloc, r_act, r_fired, r_per_mode;
    logic [TICK_WIDTH-1:0] r_pers [TIMER_COUNT];
    logic [TICK_WIDTH-1:0] r_exp  [TIMER_COUNT];
    logic [SW-1:0]         r_order [TIMER_COUNT];
    logic [CW-1:0]         r_cnt, r_pos;
    logic [CW-1:0]         r_tpos;     // tick scan position
    logic [SW-1:0]         r_tgt;      // slot being placed or removed
    logic [TICK_WIDTH-1:0] r_texp;     // expiry of that slot
    logic                  r_ovalid;
    logic [7:0]            r_odata;
    logic                  r_olast;
    logic                  r_hold_v;   // fired word waiting to learn if it is the last
    logic [SW-1:0]         r_hold_id;

    logic [SW-1:0]         w_free;
    logic                  w_has_free;
    logic [SW-1:0]         w_hslot;
    logic [SW-1:0]         w_pid, w_tid;
    logic [TICK_WIDTH-1:0] w_diff, w_dl;
    logic [TICK_WIDTH-1:0] w_per;

    assign w_hslot = SW'(r_handle);
    assign w_per   = TICK_WIDTH'(r_period);
    assign w_pid   = r_order[r_pos[SW-1:0]];
    assign w_tid   = r_order[r_tpos[SW-1:0]];

    always_comb begin
        w_free = '0;
        w_has_free = 1'b0;
        for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                w_free = SW'(i);
                w_has_free = 1'b1;
            end
        end
    end

    // wrap-aware compares of list entry against target and of tick against tick scan entry
    assign w_dl   = r_exp[w_pid] - r_texp;
    assign w_diff = r_tick - r_exp[w_tid];

    always_comb begin
        o_sts.op            = r_op;
        o_sts.hvalid        = (int'(r_handle) < TIMER_COUNT) && r_alloc[w_hslot];
        o_sts.per_zero      = (r_period == '0);
        o_sts.act           = r_act[w_hslot];
        o_sts.have_free     = w_has_free;
        o_sts.scan_end      = (r_pos >= r_cnt);
        o_sts.scan_hit      = (w_pid == r_tgt);
        o_sts.ins_here      = (w_dl != '0) && !w_dl[TICK_WIDTH-1];
        o_sts.tick_end      = (r_tpos >= r_cnt);
        o_sts.head_fired    = r_fired[w_tid];
        o_sts.head_due      = !w_diff[TICK_WIDTH-1];
        o_sts.head_periodic = r_per_mode[w_tid];
        o_sts.out_busy      = r_ovalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_alloc  <= '0;
            r_act    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_fired  <= '0;
            r_hold_v <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (i_cmd.load) begin
                r_op     <= i_word[2:0];
                r_handle <= i_word[6:3];
                r_period <= i_word[38:7];
                r_mode   <= i_word[39];
                r_fired  <= '0;
            end
            if (i_cmd.find_start) begin
                r_pos  <= '0;
                r_tpos <= '0;
                r_tgt  <= (i_cmd.create) ? w_free : w_hslot;
            end
            if (i_cmd.pos_inc) r_pos <= r_pos + 1'b1;
            if (i_cmd.tpos_inc) r_tpos <= r_tpos + 1'b1;
            if (i_cmd.remove) begin
                for (int i = 0; i < TIMER_COUNT - 1; i++)
                    if (CW'(i) >= r_pos) r_order[i] <= r_order[i+1];
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.ins_prep) begin
                r_pos  <= '0;
                r_texp <= r_tick + (i_cmd.set_period ? w_per : r_pers[w_hslot]);
                r_tgt  <= w_hslot;
            end
            if (i_cmd.ins_tick) begin
                r_pos  <= '0;
                r_texp <= r_exp[r_tgt] + r_pers[r_tgt];
            end
            if (i_cmd.ins_shift) begin
                for (int i = 1; i < TIMER_COUNT; i++)
                    if (CW'(i) > r_pos) r_order[i] <= r_order[i-1];
                r_order[r_pos[SW-1:0]] <= r_tgt;
                r_exp[r_tgt] <= r_texp;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.set_active) r_act[r_tgt] <= 1'b1;
            if (i_cmd.clr_active) r_act[r_tgt] <= 1'b0;
            if (i_cmd.create) begin
                r_alloc[w_free]    <= 1'b1;
                r_act[w_free]      <= 1'b0;
                r_per_mode[w_free] <= r_mode;
                r_pers[w_free]     <= w_per;
                r_exp[w_free]      <= '0;
            end
            if (i_cmd.delete) begin
                r_alloc[w_hslot] <= 1'b0;
                r_act[w_hslot]   <= 1'b0;
            end
            if (i_cmd.set_period) r_pers[w_hslot] <= w_per;
            if (i_cmd.tick_inc) r_tick <= r_tick + 1'b1;
            if (i_cmd.mark_fired) begin
                r_fired[w_tid] <= 1'b1;
                r_tgt <= w_tid;
                r_pos <= r_tpos;
            end
            // a fired word goes out once the next one is known
            if (i_cmd.emit_evt) begin
                if (r_hold_v) begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {1'b0, ID_W'(r_hold_id), ST_OK, 1'b1};
                    r_olast  <= 1'b0;
                end
                r_hold_v  <= 1'b1;
                r_hold_id <= w_tid;
            end
            if (i_cmd.last && r_hold_v) begin
                r_ovalid <= 1'b1;
                r_odata  <= {1'b0, ID_W'(r_hold_id), ST_OK, 1'b1};
                r_olast  <= 1'b1;
                r_hold_v <= 1'b0;
            end
            if (i_cmd.emit_stat) begin
                r_ovalid <= 1'b1;
                r_odata  <= {1'b0, (i_cmd.create ? ID_W'(w_free) : ID_W'(0)),
                             i_cmd.status, 1'b0};
                r_olast  <= 1'b1;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
endmodule
`default_nettype wire

// ===== hdl/smst_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smst_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire smst_pkg::t_sts i_sts,
    output smst_pkg::t_cmd      o_cmd
);
    import smst_pkg::*;
    t_state r_state, n_state;
    logic   r_tick_mode;  // insert path belongs to a tick
    logic   r_ins_set, n_ins_set;  // insert path came from start or period change
    logic   r_fired_any, n_fired_any;
    logic   n_tick_mode;
    logic   r_ctl_ok, n_ctl_ok;  // handle and period check taken at decode

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick_mode <= 1'b0;
            r_ins_set   <= 1'b0;
            r_fired_any <= 1'b0;
            r_ctl_ok    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick_mode <= n_tick_mode;
            r_ins_set   <= n_ins_set;
            r_fired_any <= n_fired_any;
            r_ctl_ok    <= n_ctl_ok;
        end
    end

    wire w_ctl_ok = i_sts.hvalid && !(i_sts.op == OP_CHPER && i_sts.per_zero);

    // next state
    always_comb begin
        n_state     = r_state;
        n_tick_mode = r_tick_mode;
        n_ins_set   = r_ins_set;
        n_fired_any = r_fired_any;
        n_ctl_ok    = r_ctl_ok;
        case (r_state)
            S_IDLE: if (i_valid && !i_sts.out_busy) n_state = S_DECODE;
            S_DECODE: begin
                n_tick_mode = 1'b0;
                n_fired_any = 1'b0;
                n_ins_set   = 1'b0;
                n_ctl_ok    = w_ctl_ok;
                case (i_sts.op)
                    OP_TICK: begin
                        n_tick_mode = 1'b1;
                        n_state = S_TICK_CHECK;
                    end
                    OP_DELETE, OP_START, OP_STOP, OP_CHPER: begin
                        if (!w_ctl_ok) n_state = S_STAT_EMIT;
                        else if (i_sts.act) begin
                            n_state = S_FIND;
                            n_ins_set = (i_sts.op == OP_START || i_sts.op == OP_CHPER);
                        end else if (i_sts.op == OP_START || i_sts.op == OP_CHPER)
                            n_state = S_INS_SEEK;
                        else n_state = S_STAT_EMIT;
                    end
                    default: n_state = S_STAT_EMIT;
                endcase
            end
            S_FIND: begin
                if (i_sts.scan_end) n_state = S_STAT_EMIT;
                else if (i_sts.scan_hit) n_state = S_REMOVE;
            end
            S_REMOVE: n_state = r_ins_set ? S_INS_SEEK : S_STAT_EMIT;
            S_INS_SEEK: if (i_sts.scan_end || i_sts.ins_here) n_state = S_INS_SHIFT;
            S_INS_SHIFT: n_state = r_tick_mode ? S_TICK_CHECK : S_STAT_EMIT;
            S_TICK_CHECK: begin
                if (!i_sts.out_busy) begin
                    if (i_sts.tick_end) begin
                        n_state = S_IDLE;
                    end else if (!i_sts.head_fired) begin
                        if (!i_sts.head_due) begin
                            n_state = S_IDLE;
                        end else begin
                            n_fired_any = 1'b1;
                            n_state = S_TICK_EMIT;
                        end
                    end
                end
            end
            S_TICK_EMIT: n_state = i_sts.head_periodic ? S_INS_SEEK : S_TICK_CHECK;
            S_STAT_EMIT: if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_ready = (r_state == S_IDLE) && !i_sts.out_busy;
        case (r_state)
            S_IDLE: o_cmd.load = i_valid && !i_sts.out_busy;
            S_DECODE: begin
                case (i_sts.op)
                    OP_TICK: begin
                        o_cmd.tick_inc = 1'b1;
                        o_cmd.find_start = 1'b1;
                    end
                    OP_DELETE, OP_START, OP_STOP, OP_CHPER: begin
                        if (w_ctl_ok) begin
                            if (i_sts.act) o_cmd.find_start = 1'b1;
                            if (i_sts.op == OP_DELETE) o_cmd.delete = 1'b1;
                            if (i_sts.op == OP_CHPER) o_cmd.set_period = 1'b1;
                            if (!i_sts.act && i_sts.op != OP_DELETE && i_sts.op != OP_STOP)
                                o_cmd.ins_prep = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_FIND: begin
                if (!i_sts.scan_end && !i_sts.scan_hit) o_cmd.pos_inc = 1'b1;
            end
            S_REMOVE: begin
                o_cmd.remove = 1'b1;
                if (r_ins_set) o_cmd.ins_prep = 1'b1;
                else o_cmd.clr_active = 1'b1;
            end
            S_INS_SEEK: begin
                if (!(i_sts.scan_end || i_sts.ins_here)) o_cmd.pos_inc = 1'b1;
            end
            S_INS_SHIFT: begin
                o_cmd.ins_shift = 1'b1;
                o_cmd.set_active = 1'b1;
            end
            S_TICK_CHECK: begin
                if (!i_sts.out_busy) begin
                    if (i_sts.tick_end || (!i_sts.head_fired && !i_sts.head_due)) begin
                        o_cmd.last = 1'b1;
                    end else if (i_sts.head_fired) begin
                        o_cmd.tpos_inc = 1'b1;
                    end else begin
                        o_cmd.emit_evt = 1'b1;
                        o_cmd.mark_fired = 1'b1;
                    end
                end
            end
            S_TICK_EMIT: begin
                // fired entry leaves the list; periodic ones come back further down
                o_cmd.remove = 1'b1;
                if (i_sts.head_periodic) o_cmd.ins_tick = 1'b1;
                else o_cmd.clr_active = 1'b1;
            end
            S_STAT_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit_stat = 1'b1;
                    if (i_sts.op == OP_CREATE) begin
                        if (i_sts.per_zero) o_cmd.status = ST_PARAM;
                        else if (!i_sts.have_free) o_cmd.status = ST_FULL;
                        else o_cmd.create = 1'b1;
                    end else if (i_sts.op inside {OP_DELETE, OP_START, OP_STOP, OP_CHPER}) begin
                        o_cmd.status = r_ctl_ok ? ST_OK : ST_PARAM;
                    end else o_cmd.status = ST_PARAM;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/sorted_multi_channel_soft_timer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pool of one-shot and periodic timers kept in an expiry-ordered list. Each
// control word returns one status word with tlast set; a tick returns one
// fired word per expiring timer, in expiry order, and nothing when none
// expires. A fired word is held until the next expiry check so that the
// final one of a tick carries tlast. A control word passes decode and, as
// needed, the single-step list walks for removal and insertion in the
// controller before its status word goes out. For each fired timer a tick
// does a check and a removal and, when periodic, a walk to put it back into
// the list; an entry that already fired in this tick is stepped over. A new
// word is taken only once the previous output word has left.
module sorted_multi_channel_soft_timer_core #(
    parameter int TIMER_COUNT = smst_pkg::TIMER_COUNT_DEF,
    parameter int TICK_WIDTH  = smst_pkg::TICK_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[2:0], handle[6:3], period[38:7], mode[39]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // kind[0], status[2:1], timer_id[6:3]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);
    import smst_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;

    smst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    smst_datapath #(.TIMER_COUNT(TIMER_COUNT), .TICK_WIDTH(TICK_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(s_axis_tdata), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule
`default_nettype wire

// ===== hdl/smst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_multi_channel_soft_timer_core_assert.svh"
module smst_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);
    `SMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word dropped")
    `SMT_ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid, "input taken while output pending")
    `SMT_ASSERT_IMPL(a_evt_status, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[2:1] == 2'd0, "event with nonzero status")
    `SMT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "two words accepted back to back")
endmodule
bind sorted_multi_channel_soft_timer_core smst_checker u_chk (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import smst_pkg::*;

    localparam int N_SLOT = 16;
    localparam bit [2:0] OP_BAD6 = 3'd6;
    localparam bit [2:0] OP_BAD7 = 3'd7;
    localparam int N_RAND = 300;
    localparam int N_DIR = 19;

    typedef struct packed {
        bit kind;
        bit [1:0] status;
        bit [3:0] id;
        bit last;
    } t_res;

    typedef struct packed {
        bit [2:0] op;
        bit [3:0] handle;
        bit [31:0] period;
        bit mode;
        bit typed;
        t_res typed_res;
    } t_stim;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // opcode[2:0], handle[6:3], period[38:7], mode[39]
    logic [47:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // kind[0], status[2:1], timer_id[6:3]
    logic [7:0] m_axis_tdata;
    logic m_axis_tlast;

    sorted_multi_channel_soft_timer_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // timer pool shadow
    bit [31:0] tick_now;
    bit slot_used[N_SLOT];
    bit slot_run[N_SLOT];
    bit slot_rep[N_SLOT];
    bit [31:0] slot_len[N_SLOT];
    bit [31:0] slot_due[N_SLOT];
    bit [3:0] run_list[N_SLOT];
    int run_len;

    t_res pending_words[$];
    t_stim cur_word;
    int send_idle_pct;
    int recv_stall_pct;
    int n_fail;
    int n_items;
    int n_checked;
    int n_fired;

    function automatic bit due_later(bit [31:0] a, bit [31:0] b);
        bit [31:0] d;
        d = a - b;
        return d != 0 && !d[31];
    endfunction

    function automatic void list_drop_at(int pos);
        for (int i = pos; i + 1 < run_len; i++) run_list[i] = run_list[i + 1];
        run_len--;
    endfunction

    function automatic void list_drop_id(bit [3:0] id);
        for (int i = 0; i < run_len; i++) begin
            if (run_list[i] == id) begin
                list_drop_at(i);
                return;
            end
        end
    endfunction

    // newcomer goes after all entries with the same expiry
    function automatic void list_place(bit [3:0] id);
        int pos;
        pos = 0;
        while (pos < run_len && !due_later(slot_due[run_list[pos]], slot_due[id])) pos++;
        for (int i = run_len; i > pos; i--) run_list[i] = run_list[i - 1];
        run_list[pos] = id;
        run_len++;
    endfunction

    function automatic void arm_slot(bit [3:0] id);
        if (slot_run[id]) list_drop_id(id);
        slot_run[id] = 1;
        slot_due[id] = tick_now + slot_len[id];
        list_place(id);
    endfunction

    function automatic void push_status(bit [1:0] st, bit [3:0] id);
        t_res r;
        r.kind = 0;
        r.status = st;
        r.id = id;
        r.last = 1;
        pending_words.push_back(r);
    endfunction

    function automatic void predict_timer(t_stim w);
        bit fired[N_SLOT];
        int pos;
        int n;
        bit [3:0] id;
        bit [3:0] h;
        bit [1:0] st;
        t_res r;
        h = w.handle;
        if (w.op == OP_TICK) begin
            for (int i = 0; i < N_SLOT; i++) fired[i] = 0;
            tick_now = tick_now + 1;
            pos = 0;
            n = 0;
            while (pos < run_len) begin
                id = run_list[pos];
                if (fired[id]) begin
                    pos++;
                    continue;
                end
                if (tick_now - slot_due[id] >= 32'h8000_0000) break;
                fired[id] = 1;
                r.kind = 1;
                r.status = ST_OK;
                r.id = id;
                r.last = 0;
                pending_words.push_back(r);
                n++;
                list_drop_at(pos);
                if (slot_rep[id]) begin
                    slot_due[id] = slot_due[id] + slot_len[id];
                    list_place(id);
                end else begin
                    slot_run[id] = 0;
                end
            end
            if (n > 0) pending_words[$].last = 1;
            n_fired += n;
        end else if (w.op == OP_CREATE) begin
            id = 0;
            if (w.period == 0) begin
                st = ST_PARAM;
            end else begin
                st = ST_FULL;
                for (int i = 0; i < N_SLOT; i++) begin
                    if (!slot_used[i]) begin
                        slot_used[i] = 1;
                        slot_run[i] = 0;
                        slot_rep[i] = w.mode;
                        slot_len[i] = w.period;
                        slot_due[i] = 0;
                        st = ST_OK;
                        id = 4'(i);
                        break;
                    end
                end
            end
            push_status(st, id);
        end else if (w.op >= OP_DELETE && w.op <= OP_CHPER) begin
            if (!slot_used[h] || (w.op == OP_CHPER && w.period == 0)) begin
                push_status(ST_PARAM, 0);
            end else begin
                if (w.op == OP_DELETE) begin
                    if (slot_run[h]) list_drop_id(h);
                    slot_run[h] = 0;
                    slot_used[h] = 0;
                end else if (w.op == OP_START) begin
                    arm_slot(h);
                end else if (w.op == OP_STOP) begin
                    if (slot_run[h]) begin
                        slot_run[h] = 0;
                        list_drop_id(h);
                    end
                end else begin
                    slot_len[h] = w.period;
                    arm_slot(h);
                end
                push_status(ST_OK, 0);
            end
        end else begin
            push_status(ST_PARAM, 0);
        end
    endfunction

    function automatic t_stim mk_word(bit [2:0] op, bit [3:0] h, bit [31:0] p, bit m,
                                      bit typed, bit [1:0] st, bit [3:0] id);
        t_stim w;
        w.op = op;
        w.handle = h;
        w.period = p;
        w.mode = m;
        w.typed = typed;
        w.typed_res.kind = 0;
        w.typed_res.status = st;
        w.typed_res.id = id;
        w.typed_res.last = 1;
        return w;
    endfunction

    function automatic bit [31:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(12, 1);
        if (r < 80) return $urandom;
        if (r < 85) return 0;
        if (r < 95) return $urandom | 32'h8000_0000;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic bit [3:0] pick_handle();
        int cnt;
        int k;
        cnt = 0;
        for (int i = 0; i < N_SLOT; i++) cnt += slot_used[i];
        if (cnt == 0 || $urandom_range(99) < 15) return 4'($urandom_range(15));
        k = $urandom_range(cnt - 1);
        for (int i = 0; i < N_SLOT; i++) begin
            if (slot_used[i]) begin
                if (k == 0) return 4'(i);
                k--;
            end
        end
        return 0;
    endfunction

    function automatic t_stim gen_word();
        int r;
        bit [2:0] op;
        r = $urandom_range(99);
        if (r < 35) op = OP_TICK;
        else if (r < 48) op = OP_CREATE;
        else if (r < 60) op = OP_DELETE;
        else if (r < 77) op = OP_START;
        else if (r < 86) op = OP_STOP;
        else if (r < 97) op = OP_CHPER;
        else op = $urandom_range(1) ? OP_BAD6 : OP_BAD7;
        return mk_word(op, pick_handle(), pick_period(), 1'($urandom_range(1)), 0, ST_OK, 0);
    endfunction

    task automatic send_word(t_stim w);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 0;
        end
        @(negedge i_clk);
        cur_word = w;
        s_axis_tvalid <= 1;
        s_axis_tdata <= {8'd0, w.mode, w.period, w.handle, w.op};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            n_items++;
            predict_timer(cur_word);
            if (cur_word.typed) pending_words[$] = cur_word.typed_res;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word %h last %b", m_axis_tdata, m_axis_tlast);
                n_fail++;
            end else begin
                e = pending_words.pop_front();
                n_checked++;
                if (m_axis_tdata[0] !== e.kind) begin
                    $error("kind: expected %0d actual %0d", e.kind, m_axis_tdata[0]);
                    n_fail++;
                end
                if (m_axis_tdata[2:1] !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, m_axis_tdata[2:1]);
                    n_fail++;
                end
                if (m_axis_tdata[6:3] !== e.id) begin
                    $error("timer_id: expected %0d actual %0d", e.id, m_axis_tdata[6:3]);
                    n_fail++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0d actual %0d", e.last, m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_stim dir_tab[N_DIR];
        int wait_cnt;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        i_rst_n = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_fail = 0;
        n_items = 0;
        n_checked = 0;
        n_fired = 0;
        tick_now = 0;
        run_len = 0;
        for (int i = 0; i < N_SLOT; i++) begin
            slot_used[i] = 0;
            slot_run[i] = 0;
            slot_rep[i] = 0;
            slot_len[i] = 0;
            slot_due[i] = 0;
            run_list[i] = 0;
        end
        dir_tab[0] = mk_word(OP_TICK, 0, 0, 0, 0, ST_OK, 0);
        dir_tab[1] = mk_word(OP_CREATE, 0, 0, 1, 1, ST_PARAM, 0);
        dir_tab[2] = mk_word(OP_DELETE, 5, 0, 0, 1, ST_PARAM, 0);
        dir_tab[3] = mk_word(OP_BAD6, 15, 32'hFFFF_FFFF, 1, 1, ST_PARAM, 0);
        dir_tab[4] = mk_word(OP_BAD7, 0, 0, 0, 1, ST_PARAM, 0);
        dir_tab[5] = mk_word(OP_CREATE, 15, 32'hFFFF_FFFF, 1, 1, ST_OK, 0);
        dir_tab[6] = mk_word(OP_CREATE, 0, 1, 0, 1, ST_OK, 1);
        dir_tab[7] = mk_word(OP_START, 0, 0, 0, 0, ST_OK, 0);
        dir_tab[8] = mk_word(OP_START, 1, 0, 0, 0, ST_OK, 0);
        dir_tab[9] = mk_word(OP_TICK, 0, 0, 0, 0, ST_OK, 0);
        dir_tab[10] = mk_word(OP_TICK, 0, 0, 0, 0, ST_OK, 0);
        dir_tab[11] = mk_word(OP_STOP, 1, 0, 0, 0, ST_OK, 0);
        dir_tab[12] = mk_word(OP_STOP, 1, 0, 0, 0, ST_OK, 0);
        dir_tab[13] = mk_word(OP_CHPER, 0, 0, 0, 1, ST_PARAM, 0);
        dir_tab[14] = mk_word(OP_CHPER, 0, 32'h8000_0000, 0, 0, ST_OK, 0);
        dir_tab[15] = mk_word(OP_TICK, 0, 0, 0, 0, ST_OK, 0);
        dir_tab[16] = mk_word(OP_DELETE, 0, 0, 0, 0, ST_OK, 0);
        dir_tab[17] = mk_word(OP_START, 0, 0, 0, 1, ST_PARAM, 0);
        dir_tab[18] = mk_word(OP_DELETE, 15, 0, 0, 1, ST_PARAM, 0);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        for (int i = 0; i < N_DIR; i++) send_word(dir_tab[i]);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 85 : (ph == 3) ? 19 : 0;
            recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 19 : 0;
            for (int i = 0; i < N_RAND / 4; i++) send_word(gen_word());
        end
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        recv_stall_pct = 0;
        wait_cnt = 0;
        while (pending_words.size() != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (100) @(posedge i_clk);
        $display("ran %0d words through the timer pool, checked %0d results (%0d fired)",
                 n_items, n_checked, n_fired);
        if (n_fail == 0 && pending_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/smst_pkg.sv
hdl/smst_datapath.sv
hdl/smst_ctrl.sv
hdl/sorted_multi_channel_soft_timer_core.sv
hdl/smst_checker.sv
tb/tb_top.sv
